// ===== hw/rtl/scaled_monomial_basis_eval_defines.svh =====
`ifndef SCALED_MONOMIAL_BASIS_EVAL_DEFINES_SVH
`define SCALED_MONOMIAL_BASIS_EVAL_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SMBE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SMBE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/smbe_pkg.sv =====
package smbe_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_CENTER_X    = 3'd0;
	localparam logic [2:0] REG_CENTER_Y    = 3'd1;
	localparam logic [2:0] REG_INV_EXT_X   = 3'd2;
	localparam logic [2:0] REG_INV_EXT_Y   = 3'd3;
	localparam logic [2:0] REG_TOTAL_ORDER = 3'd4;

	localparam logic [31:0] INV_EXT_RESET     = 32'h0001_0000;
	localparam logic [3:0]  TOTAL_ORDER_RESET = 4'd15;

	// function selector codes
	localparam logic [2:0] FUNC_VALUE = 3'd0;
	localparam logic [2:0] FUNC_DX    = 3'd1;
	localparam logic [2:0] FUNC_DY    = 3'd2;
	localparam logic [2:0] FUNC_D2X   = 3'd3;
	localparam logic [2:0] FUNC_DXY   = 3'd4;
	localparam logic [2:0] FUNC_D2Y   = 3'd5;

	// rounding shifts: coordinates go Q16.16 x Q16.16 -> Q24.24, products stay Q24.24
	localparam int unsigned COORD_SHIFT = 8;
	localparam int unsigned FRAC_SHIFT  = 24;

	localparam logic [47:0] LIM_POS = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0] LIM_NEG = 48'h8000_0000_0000;

	typedef struct packed {
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic [31:0]        inv_ext_x;
		logic [31:0]        inv_ext_y;
		logic [3:0]         total_order;
	} cfg_t;

	typedef struct packed {
		logic               start;
		logic               coord;
		logic signed [47:0] a;
		logic signed [47:0] b;
	} mul_req_t;

	typedef struct packed {
		logic               done;
		logic               sat;
		logic signed [47:0] result;
	} mul_rsp_t;

	typedef enum logic [2:0] {
		MP_IDLE,
		MP_PP0,
		MP_PP1,
		MP_PP2,
		MP_PP3,
		MP_RND
	} mul_phase_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DEG,
		S_SETUP,
		S_PICK,
		S_WAIT
	} seq_state_t;

	typedef enum logic [2:0] {
		OP_DU,
		OP_DV,
		OP_PX,
		OP_PY,
		OP_SX,
		OP_SY
	} mul_op_t;

endpackage

// ===== hw/rtl/smbe_mul.sv =====
`include "scaled_monomial_basis_eval_defines.svh"

module smbe_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  smbe_pkg::mul_req_t req,
	output smbe_pkg::mul_rsp_t rsp
);
	import smbe_pkg::*;

	localparam int unsigned OP_W   = 48;
	localparam int unsigned HALF_W = OP_W / 2;
	localparam int unsigned PROD_W = 2 * OP_W;
	localparam int unsigned MAG_W  = PROD_W - COORD_SHIFT;

	mul_phase_t phase_q, phase_d;

	logic [OP_W-1:0]     ma_q, mb_q;
	logic                neg_q, coord_q;
	logic [PROD_W-1:0]   prod_q;
	logic [OP_W-1:0]     mag_q;
	logic                sat_q, done_q;

	logic [OP_W-1:0]     abs_a, abs_b;
	logic [HALF_W-1:0]   pa, pb;
	logic [2*HALF_W-1:0] pp;
	logic [PROD_W-1:0]   pp_sh, half, rnd;
	logic [MAG_W-1:0]    shifted;
	logic [OP_W-1:0]     lim, mag_d;
	logic                over;

	assign abs_a = req.a[OP_W-1] ? OP_W'(~req.a + 1'b1) : req.a;
	assign abs_b = req.b[OP_W-1] ? OP_W'(~req.b + 1'b1) : req.b;

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			MP_IDLE: if (req.start) phase_d = MP_PP0;
			MP_PP0:  phase_d = MP_PP1;
			MP_PP1:  phase_d = MP_PP2;
			MP_PP2:  phase_d = MP_PP3;
			MP_PP3:  phase_d = MP_RND;
			MP_RND:  phase_d = MP_IDLE;
			default: phase_d = MP_IDLE;
		endcase
	end

	// one 24x24 partial product a cycle
	always_comb begin
		unique case (phase_q)
			MP_PP1: begin
				pa = ma_q[HALF_W-1:0];
				pb = mb_q[OP_W-1:HALF_W];
			end
			MP_PP2: begin
				pa = ma_q[OP_W-1:HALF_W];
				pb = mb_q[HALF_W-1:0];
			end
			MP_PP3: begin
				pa = ma_q[OP_W-1:HALF_W];
				pb = mb_q[OP_W-1:HALF_W];
			end
			default: begin
				pa = ma_q[HALF_W-1:0];
				pb = mb_q[HALF_W-1:0];
			end
		endcase
	end

	assign pp = pa * pb;

	always_comb begin
		unique case (phase_q)
			MP_PP1, MP_PP2: pp_sh = PROD_W'(pp) << HALF_W;
			MP_PP3:         pp_sh = PROD_W'(pp) << (2 * HALF_W);
			default:        pp_sh = PROD_W'(pp);
		endcase
	end

	// round half away from zero on the magnitude, then clip
	assign half    = coord_q ? (PROD_W'(1) << (COORD_SHIFT - 1)) : (PROD_W'(1) << (FRAC_SHIFT - 1));
	assign rnd     = prod_q + half;
	assign shifted = coord_q ? MAG_W'(rnd >> COORD_SHIFT) : MAG_W'(rnd >> FRAC_SHIFT);
	assign lim     = neg_q ? LIM_NEG : LIM_POS;
	assign over    = shifted > MAG_W'(lim);
	assign mag_d   = over ? lim : shifted[OP_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= MP_IDLE;
			done_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			done_q  <= (phase_q == MP_RND);
		end
	end

	always_ff @(posedge clk) begin
		unique case (phase_q)
			MP_IDLE: if (req.start) begin
				ma_q    <= abs_a;
				mb_q    <= abs_b;
				neg_q   <= req.a[OP_W-1] ^ req.b[OP_W-1];
				coord_q <= req.coord;
				prod_q  <= '0;
			end
			MP_PP0, MP_PP1, MP_PP2, MP_PP3: prod_q <= prod_q + pp_sh;
			MP_RND: begin
				mag_q <= mag_d;
				sat_q <= over;
			end
			default: ;
		endcase
	end

	always_comb begin
		rsp.done   = done_q;
		rsp.sat    = sat_q;
		rsp.result = neg_q ? OP_W'(~mag_q + 1'b1) : mag_q;
	end

	`SMBE_ASSERT_SAME(a_start_idle, clk, arst_n, req.start, phase_q == MP_IDLE, "multiply issued while unit busy")
	`SMBE_ASSERT_NEXT(a_done_after_round, clk, arst_n, phase_q == MP_RND, done_q, "no done after round phase")
	`SMBE_ASSERT_SAME(a_sat_at_limit, clk, arst_n, done_q && sat_q, (mag_q == LIM_POS) || (mag_q == LIM_NEG), "clipped magnitude not at a limit")

endmodule

// ===== hw/rtl/smbe_seq.sv =====
`include "scaled_monomial_basis_eval_defines.svh"

module smbe_seq #(
	parameter int unsigned MAX_ORDER = 15
) (
	input  logic               clk,
	input  logic               arst_n,
	input  smbe_pkg::cfg_t     cfg,
	input  logic               start,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic [7:0]         basis_index,
	input  logic [2:0]         func,
	output logic               busy,
	output smbe_pkg::mul_req_t mul_req,
	input  smbe_pkg::mul_rsp_t mul_rsp,
	output logic               done,
	output logic signed [47:0] result_value,
	output logic               error_flag,
	output logic               saturated
);
	import smbe_pkg::*;

	localparam int unsigned EW    = $clog2(MAX_ORDER + 1);
	localparam int unsigned XW    = EW + 2;
	localparam int unsigned CW    = 2 * EW;
	localparam int unsigned TRI_W = 8;
	localparam logic [4:0]  MAX_ORD5 = 5'(MAX_ORDER);

	seq_state_t state_q, state_d;

	logic signed [31:0] px_q, py_q;
	logic [7:0]         idx_q;
	logic [2:0]         func_q;
	logic [EW-1:0]      o_q, ex_q, ey_q, cnt_px_q, cnt_py_q;
	logic [1:0]         cnt_sx_q, cnt_sy_q;
	logic               need_du_q, need_dv_q;
	logic [TRI_W-1:0]   tri_base_q, tri_next_q;
	logic signed [32:0] diff_x_q, diff_y_q;
	logic signed [47:0] acc_q, du_q, dv_q;
	logic               sat_q;
	mul_op_t            op_q, op_sel;
	logic               op_any;

	logic               done_q, err_q, satout_q;
	logic signed [47:0] result_q;

	logic [4:0]         t5;
	logic [EW-1:0]      t_ord;
	logic               func_bad, deg_hit, at_top, deg_err, vanish;
	logic [TRI_W-1:0]   k_val;
	logic [1:0]         cx, cy;
	logic [EW-1:0]      ca, cb;
	logic [CW-1:0]      coef;
	logic [XW-1:0]      ia_full, ib_full;

	logic               fin, fin_err, fin_sat;
	logic signed [47:0] fin_val;

	assign t5    = ({1'b0, cfg.total_order} > MAX_ORD5) ? MAX_ORD5 : {1'b0, cfg.total_order};
	assign t_ord = t5[EW-1:0];

	// degree search walks the triangular numbers one step a cycle
	assign func_bad = func_q > FUNC_D2Y;
	assign deg_hit  = idx_q >= tri_next_q;
	assign at_top   = o_q == t_ord;
	assign deg_err  = func_bad || (deg_hit && at_top);
	assign k_val    = idx_q - tri_base_q;

	always_comb begin
		cx = 2'd0;
		cy = 2'd0;
		ca = EW'(1);
		cb = EW'(1);
		unique case (func_q)
			FUNC_VALUE: ;
			FUNC_DX: begin
				cx = 2'd1;
				ca = ex_q;
			end
			FUNC_DY: begin
				cy = 2'd1;
				ca = ey_q;
			end
			FUNC_D2X: begin
				cx = 2'd2;
				ca = ex_q;
				cb = EW'(ex_q - 1'b1);
			end
			FUNC_DXY: begin
				cx = 2'd1;
				cy = 2'd1;
				ca = ex_q;
				cb = ey_q;
			end
			FUNC_D2Y: begin
				cy = 2'd2;
				ca = ey_q;
				cb = EW'(ey_q - 1'b1);
			end
			default: ;
		endcase
	end

	assign coef    = CW'(ca) * CW'(cb);
	assign ia_full = XW'(ex_q) - XW'(cx);
	assign ib_full = XW'(ey_q) - XW'(cy);
	assign vanish  = ia_full[XW-1] | ib_full[XW-1];

	// coordinates first, then powers of du, powers of dv, x scales, y scales
	always_comb begin
		op_sel = OP_DU;
		op_any = 1'b1;
		priority if (need_du_q) op_sel = OP_DU;
		else if (need_dv_q)     op_sel = OP_DV;
		else if (cnt_px_q != '0) op_sel = OP_PX;
		else if (cnt_py_q != '0) op_sel = OP_PY;
		else if (cnt_sx_q != '0) op_sel = OP_SX;
		else if (cnt_sy_q != '0) op_sel = OP_SY;
		else op_any = 1'b0;
	end

	always_comb begin
		mul_req.start = (state_q == S_PICK) && op_any;
		mul_req.coord = (op_sel == OP_DU) || (op_sel == OP_DV);
		mul_req.a     = acc_q;
		unique case (op_sel)
			OP_DU: begin
				mul_req.a = 48'(diff_x_q);
				mul_req.b = $signed({16'b0, cfg.inv_ext_x});
			end
			OP_DV: begin
				mul_req.a = 48'(diff_y_q);
				mul_req.b = $signed({16'b0, cfg.inv_ext_y});
			end
			OP_PX:   mul_req.b = du_q;
			OP_PY:   mul_req.b = dv_q;
			OP_SX:   mul_req.b = $signed({8'b0, cfg.inv_ext_x, 8'b0});
			OP_SY:   mul_req.b = $signed({8'b0, cfg.inv_ext_y, 8'b0});
			default: mul_req.b = du_q;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (start) state_d = S_DEG;
			S_DEG: begin
				if (deg_err) state_d = S_IDLE;
				else if (!deg_hit) state_d = S_SETUP;
			end
			S_SETUP: state_d = vanish ? S_IDLE : S_PICK;
			S_PICK:  state_d = op_any ? S_WAIT : S_IDLE;
			S_WAIT:  if (mul_rsp.done) state_d = S_PICK;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		busy    = state_q != S_IDLE;
		fin     = 1'b0;
		fin_err = 1'b0;
		fin_sat = 1'b0;
		fin_val = '0;
		unique case (state_q)
			S_DEG: if (deg_err) begin
				fin     = 1'b1;
				fin_err = 1'b1;
			end
			S_SETUP: fin = vanish;
			S_PICK: if (!op_any) begin
				fin     = 1'b1;
				fin_val = acc_q;
				fin_sat = sat_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (start) begin
				px_q       <= point_x;
				py_q       <= point_y;
				idx_q      <= basis_index;
				func_q     <= func;
				o_q        <= '0;
				tri_base_q <= '0;
				tri_next_q <= TRI_W'(1);
			end
			S_DEG: begin
				if (deg_hit && !at_top) begin
					o_q        <= EW'(o_q + 1'b1);
					tri_base_q <= tri_next_q;
					tri_next_q <= TRI_W'(tri_next_q + TRI_W'(o_q) + TRI_W'(2));
				end else if (!deg_hit) begin
					ex_q <= EW'(o_q - k_val[EW-1:0]);
					ey_q <= k_val[EW-1:0];
				end
			end
			S_SETUP: begin
				cnt_px_q  <= ia_full[EW-1:0];
				cnt_py_q  <= ib_full[EW-1:0];
				cnt_sx_q  <= cx;
				cnt_sy_q  <= cy;
				need_du_q <= ia_full != '0;
				need_dv_q <= ib_full != '0;
				acc_q     <= $signed(48'(coef) << FRAC_SHIFT);
				sat_q     <= 1'b0;
				diff_x_q  <= 33'(px_q) - 33'(cfg.center_x);
				diff_y_q  <= 33'(py_q) - 33'(cfg.center_y);
			end
			S_PICK: if (op_any) op_q <= op_sel;
			S_WAIT: if (mul_rsp.done) begin
				sat_q <= sat_q | mul_rsp.sat;
				unique case (op_q)
					OP_DU: begin
						du_q      <= mul_rsp.result;
						need_du_q <= 1'b0;
					end
					OP_DV: begin
						dv_q      <= mul_rsp.result;
						need_dv_q <= 1'b0;
					end
					OP_PX: begin
						acc_q    <= mul_rsp.result;
						cnt_px_q <= EW'(cnt_px_q - 1'b1);
					end
					OP_PY: begin
						acc_q    <= mul_rsp.result;
						cnt_py_q <= EW'(cnt_py_q - 1'b1);
					end
					OP_SX: begin
						acc_q    <= mul_rsp.result;
						cnt_sx_q <= cnt_sx_q - 1'b1;
					end
					OP_SY: begin
						acc_q    <= mul_rsp.result;
						cnt_sy_q <= cnt_sy_q - 1'b1;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
		if (fin) begin
			result_q <= fin_val;
			err_q    <= fin_err;
			satout_q <= fin_sat;
		end
	end

	assign done         = done_q;
	assign result_value = result_q;
	assign error_flag   = err_q;
	assign saturated    = satout_q;

	`SMBE_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, start && !busy, busy, "accepted item left the block idle")
	`SMBE_ASSERT_SAME(a_error_clean, clk, arst_n, done_q && err_q, (result_q == '0) && !satout_q, "error result not cleared")
	`SMBE_ASSERT_SAME(a_rsp_in_wait, clk, arst_n, mul_rsp.done, state_q == S_WAIT, "multiply result with nobody waiting")
	`SMBE_ASSERT_SAME(a_strobe_idle, clk, arst_n, done_q, state_q == S_IDLE, "result strobe while still working")

endmodule

// ===== hw/rtl/scaled_monomial_basis_eval.sv =====
// Evaluates one member of a scaled 2D monomial basis, or one of its first or second
// partial derivatives, at a Q16.16 point and returns a saturating Q24.24 value. An item
// is taken when start is high and busy is low; busy then stays high until the result
// appears on result_value, error_flag and saturated for exactly one cycle with done
// high. The receiver cannot stall, so every result must be captured in that cycle. All
// multiplications share one 48x48 unit built from four 24x24 partial products; it
// accumulates the partial products, then rounds and clips, and takes one multiply at
// a time. An item issues M = ia + ib + cx + cy + (ia > 0) + (ib > 0) multiplies (ia, ib
// the remaining exponents, cx, cy the derivative counts); selector or index errors
// return without any multiply. The configuration port is always ready and must only
// be written while busy is low; out-of-range register indexes are ignored.
module scaled_monomial_basis_eval #(
	parameter int unsigned MAX_ORDER = 15
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic [7:0]         basis_index,
	input  logic [2:0]         func,
	output logic               done,
	output logic signed [47:0] result_value,
	output logic               error_flag,
	output logic               saturated,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import smbe_pkg::*;

	cfg_t     cfg_q;
	mul_req_t mul_req;
	mul_rsp_t mul_rsp;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x    <= '0;
			cfg_q.center_y    <= '0;
			cfg_q.inv_ext_x   <= INV_EXT_RESET;
			cfg_q.inv_ext_y   <= INV_EXT_RESET;
			cfg_q.total_order <= TOTAL_ORDER_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CENTER_X:    cfg_q.center_x    <= $signed(cfg_data);
				REG_CENTER_Y:    cfg_q.center_y    <= $signed(cfg_data);
				REG_INV_EXT_X:   cfg_q.inv_ext_x   <= cfg_data;
				REG_INV_EXT_Y:   cfg_q.inv_ext_y   <= cfg_data;
				REG_TOTAL_ORDER: cfg_q.total_order <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	smbe_seq #(
		.MAX_ORDER(MAX_ORDER)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.start        (start),
		.point_x      (point_x),
		.point_y      (point_y),
		.basis_index  (basis_index),
		.func         (func),
		.busy         (busy),
		.mul_req      (mul_req),
		.mul_rsp      (mul_rsp),
		.done         (done),
		.result_value (result_value),
		.error_flag   (error_flag),
		.saturated    (saturated)
	);

	smbe_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

endmodule
